/* sv/cht_pkg.sv */
// cht_pkg: shared types, constants and op codes for the chained hash table
// no dependencies
`default_nettype none
package cht_pkg;
    localparam int CAPACITY_DEF = 1024;
    localparam int BUCKETS_DEF  = 1024;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int QDEPTH       = 2;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_DELETE  = 3'd1,
        OP_FIND    = 3'd2,
        OP_INCR    = 3'd3,
        OP_FIND_INS = 3'd4,
        OP_CLEAR   = 3'd5
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] data;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] result_value;
        logic [1:0]  status;
    } rsp_t;
endpackage
`default_nettype wire

/* sv/cht_if.sv */
// cht_req_if / cht_rsp_if: valid/ready channels for requests and results
// no dependencies
`default_nettype none
interface cht_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] data;
    modport source (output valid, output op, output key, output data, input ready);
    modport sink   (input valid, input op, input key, input data, output ready);
endinterface

interface cht_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] result_value;
    logic [1:0]  status;
    modport source (output valid, output hit, output result_value, output status, input ready);
    modport sink   (input valid, input hit, input result_value, input status, output ready);
endinterface
`default_nettype wire

/* sv/cht_ram.sv */
// cht_ram: generic single-port write, single read port RAM, registered read
// no dependencies
`default_nettype none
module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* sv/cht_front.sv */
// cht_front: accepts transactions, hashes the key into a bucket, queues them
// depends on cht_pkg
`default_nettype none
module cht_front #(
    parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire cht_pkg::req_t          in_req,
    input  wire logic [cht_pkg::CFG_W-1:0] bucket_count,
    output logic                        q_valid,
    input  wire logic                   q_ready,
    output cht_pkg::req_t               q_req,
    output logic [BW-1:0]               q_bucket
);
    localparam int MW = $clog2(BUCKETS + 1) > 0 ? $clog2(BUCKETS + 1) : 1;
    localparam int SW = MW + 1;

    // bit-serial remainder of the 64-bit sign-extended key
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t      state_reg, state_next;
    cht_pkg::req_t req_reg, req_next;
    logic [63:0]  dvd_reg, dvd_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [MW-1:0] mod_reg, mod_next;

    cht_pkg::req_t q_req_mem [cht_pkg::QDEPTH];
    logic [BW-1:0] q_bkt_mem [cht_pkg::QDEPTH];
    logic          wp_reg, rp_reg;
    logic [1:0]    fill_reg;

    logic [MW-1:0] mod_eff;
    logic [SW-1:0] shifted;
    logic          push, pop;

    always_comb
    begin
        if (bucket_count == '0)
        begin
            mod_eff = MW'(1);
        end
        else if (32'(bucket_count) > 32'(BUCKETS))
        begin
            mod_eff = MW'(BUCKETS);
        end
        else
        begin
            mod_eff = MW'(bucket_count);
        end
    end

    assign in_ready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && (fill_reg != 2'(cht_pkg::QDEPTH));
    assign pop      = q_valid && q_ready;
    assign shifted  = {rem_reg[SW-2:0], dvd_reg[63]};

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        mod_next   = mod_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_req;
                    dvd_next   = {{32{in_req.key[31]}}, in_req.key};
                    rem_next   = '0;
                    cnt_next   = '0;
                    mod_next   = mod_eff;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                dvd_next = {dvd_reg[62:0], 1'b0};
                if (shifted >= SW'(mod_reg))
                begin
                    rem_next = shifted - SW'(mod_reg);
                end
                else
                begin
                    rem_next = shifted;
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        mod_reg <= mod_next;
        if (push)
        begin
            q_req_mem[wp_reg] <= req_reg;
            q_bkt_mem[wp_reg] <= BW'(rem_reg);
        end
    end

    assign q_valid  = (fill_reg != '0);
    assign q_req    = q_req_mem[rp_reg];
    assign q_bucket = q_bkt_mem[rp_reg];
endmodule
`default_nettype wire

/* sv/cht_back.sv */
// cht_back: walks chains in the head and entry memories and forms results
// depends on cht_pkg and cht_ram
`default_nettype none
module cht_back #(
    parameter int CAPACITY = cht_pkg::CAPACITY_DEF,
    parameter int BUCKETS  = cht_pkg::BUCKETS_DEF,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int IW = $clog2(CAPACITY + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    output logic                           q_ready,
    input  wire cht_pkg::req_t             q_req,
    input  wire logic [BW-1:0]             q_bucket,
    input  wire logic [cht_pkg::CFG_W-1:0] entry_limit,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output cht_pkg::rsp_t                  out_rsp
);
    localparam int EDEPTH = CAPACITY + 1;
    localparam int CW = $clog2(CAPACITY + 1) + 1;
    localparam int EPW = 16;

    // head memory carries an epoch tag so a clear need not sweep it unless the tag wraps
    typedef enum logic [8:0] {
        B_IDLE  = 9'b000000001,
        B_HEAD  = 9'b000000010,
        B_HWAIT = 9'b000000100,
        B_ENT   = 9'b000001000,
        B_EWAIT = 9'b000010000,
        B_CHECK = 9'b000100000,
        B_ADD   = 9'b001000000,
        B_RESP  = 9'b010000000,
        B_ZERO  = 9'b100000000
    } bstate_t;

    bstate_t       state_reg, state_next;
    cht_pkg::req_t req_reg;
    logic [BW-1:0] bkt_reg;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic [63:0]   pent_reg, pent_next;
    logic [CW-1:0] count_reg, count_next;
    logic [EPW-1:0] epoch_reg, epoch_next;
    logic [BW:0]   zcnt_reg, zcnt_next;
    logic          clr_rsp_reg, clr_rsp_next;
    logic          removed_reg, removed_next;
    logic          ovalid_reg, ovalid_next;
    cht_pkg::rsp_t rsp_reg, rsp_next;
    logic [CW-1:0] lim;

    logic          h_we;
    logic [BW-1:0] h_waddr, h_raddr;
    logic [IW+EPW-1:0] h_wdata, h_rdata;
    logic          e_we;
    logic [IW-1:0] e_waddr, e_raddr;
    logic [64+IW-1:0] e_wdata, e_rdata;
    logic [31:0]   e_key, e_val;
    logic [IW-1:0] e_link, h_head, nx;

    cht_ram #(.WIDTH(IW + EPW), .DEPTH(BUCKETS)) u_head (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );
    cht_ram #(.WIDTH(64 + IW), .DEPTH(EDEPTH)) u_entry (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    assign e_key  = e_rdata[64+IW-1:32+IW];
    assign e_val  = e_rdata[32+IW-1:IW];
    assign e_link = e_rdata[IW-1:0];
    assign nx     = (32'(e_link) <= 32'(CAPACITY)) ? e_link : '0;
    assign h_head = (h_rdata[IW+EPW-1:IW] == epoch_reg &&
                     32'(h_rdata[IW-1:0]) <= 32'(CAPACITY)) ? h_rdata[IW-1:0] : '0;
    assign lim = (32'(entry_limit) > 32'(CAPACITY)) ? CW'(CAPACITY) : CW'(entry_limit);
    assign h_raddr = bkt_reg;
    assign e_raddr = cur_reg;
    assign q_ready = (state_reg == B_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_rsp   = rsp_reg;

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        pent_next    = pent_reg;
        count_next   = count_reg;
        epoch_next   = epoch_reg;
        zcnt_next    = zcnt_reg;
        clr_rsp_next = clr_rsp_reg;
        removed_next = removed_reg;
        ovalid_next  = ovalid_reg;
        rsp_next     = rsp_reg;
        h_we    = 1'b0;
        h_waddr = bkt_reg;
        h_wdata = {epoch_reg, IW'(0)};
        e_we    = 1'b0;
        e_waddr = cur_reg;
        e_wdata = e_rdata;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && !ovalid_reg)
                begin
                    removed_next = 1'b0;
                    prev_next    = '0;
                    case (q_req.op)
                        cht_pkg::OP_INSERT, cht_pkg::OP_DELETE, cht_pkg::OP_FIND,
                        cht_pkg::OP_INCR, cht_pkg::OP_FIND_INS:
                        begin
                            state_next = B_HEAD;
                        end
                        cht_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            epoch_next = epoch_reg + 1'b1;
                            rsp_next   = '{1'b0, 32'd0, cht_pkg::ST_OK};
                            if (epoch_reg == '1)
                            begin
                                zcnt_next    = '0;
                                clr_rsp_next = 1'b1;
                                state_next   = B_ZERO;
                            end
                            else
                            begin
                                state_next = B_RESP;
                            end
                        end
                        default:
                        begin
                            rsp_next   = '{1'b0, 32'd0, cht_pkg::ST_OK};
                            state_next = B_RESP;
                        end
                    endcase
                end
            end
            B_ZERO:
            begin
                h_we    = 1'b1;
                h_waddr = BW'(zcnt_reg);
                h_wdata = {epoch_reg, IW'(0)};
                zcnt_next = zcnt_reg + 1'b1;
                if (32'(zcnt_reg) == 32'(BUCKETS - 1))
                begin
                    clr_rsp_next = 1'b0;
                    state_next   = clr_rsp_reg ? B_RESP : B_IDLE;
                end
            end
            B_HEAD:
            begin
                state_next = B_HWAIT;
            end
            B_HWAIT:
            begin
                if (req_reg.op == cht_pkg::OP_INSERT)
                begin
                    state_next = B_ADD;
                end
                else
                begin
                    cur_next = h_head;
                    if (h_head == '0)
                    begin
                        state_next = B_CHECK;
                    end
                    else
                    begin
                        state_next = B_ENT;
                    end
                end
            end
            B_ENT:
            begin
                state_next = B_EWAIT;
            end
            B_EWAIT:
            begin
                if (e_key == req_reg.key)
                begin
                    if (req_reg.op == cht_pkg::OP_DELETE)
                    begin
                        removed_next = 1'b1;
                        if (prev_reg == '0)
                        begin
                            h_we    = 1'b1;
                            h_wdata = {epoch_reg, nx};
                        end
                        else
                        begin
                            e_we    = 1'b1;
                            e_waddr = prev_reg;
                            e_wdata = {pent_reg, nx};
                        end
                        cur_next   = nx;
                        state_next = (nx == '0) ? B_CHECK : B_ENT;
                    end
                    else if (req_reg.op == cht_pkg::OP_INCR)
                    begin
                        e_we    = 1'b1;
                        e_wdata = {e_key, e_val + req_reg.data, e_link};
                        rsp_next = '{1'b1, e_val + req_reg.data, cht_pkg::ST_OK};
                        state_next = B_RESP;
                    end
                    else
                    begin
                        rsp_next = '{1'b1, e_val, cht_pkg::ST_OK};
                        state_next = B_RESP;
                    end
                end
                else
                begin
                    prev_next = cur_reg;
                    pent_next = {e_key, e_val};
                    cur_next  = nx;
                    state_next = (nx == '0) ? B_CHECK : B_ENT;
                end
            end
            B_CHECK:
            begin
                if (req_reg.op == cht_pkg::OP_DELETE)
                begin
                    rsp_next = removed_reg ? '{1'b1, 32'd0, cht_pkg::ST_OK}
                                           : '{1'b0, 32'hFFFF_FFFF, cht_pkg::ST_NOTFOUND};
                    state_next = B_RESP;
                end
                else if (req_reg.op == cht_pkg::OP_FIND_INS)
                begin
                    state_next = B_ADD;
                end
                else
                begin
                    rsp_next = '{1'b0, 32'hFFFF_FFFF, cht_pkg::ST_NOTFOUND};
                    state_next = B_RESP;
                end
            end
            B_ADD:
            begin
                if (count_reg >= lim)
                begin
                    rsp_next = '{1'b0, 32'hFFFF_FFFF, cht_pkg::ST_FULL};
                    state_next = B_RESP;
                end
                else
                begin
                    e_we    = 1'b1;
                    e_waddr = IW'(count_reg + 1'b1);
                    e_wdata = {req_reg.key,
                               (req_reg.op == cht_pkg::OP_INSERT) ? req_reg.data : 32'd0,
                               h_head};
                    h_we    = 1'b1;
                    h_wdata = {epoch_reg, IW'(count_reg + 1'b1)};
                    count_next = count_reg + 1'b1;
                    rsp_next = '{1'b1,
                                 (req_reg.op == cht_pkg::OP_INSERT) ? req_reg.data : 32'd0,
                                 cht_pkg::ST_OK};
                    state_next = B_RESP;
                end
            end
            B_RESP:
            begin
                ovalid_next = 1'b1;
                state_next  = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_ZERO;
            count_reg   <= '0;
            epoch_reg   <= '0;
            zcnt_reg    <= '0;
            clr_rsp_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            epoch_reg   <= epoch_next;
            zcnt_reg    <= zcnt_next;
            clr_rsp_reg <= clr_rsp_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE)
        begin
            req_reg <= q_req;
            bkt_reg <= q_bucket;
            cur_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
        end
        prev_reg    <= prev_next;
        pent_reg    <= pent_next;
        removed_reg <= removed_next;
        rsp_reg     <= rsp_next;
    end
endmodule
`default_nettype wire

/* sv/chained_hash_table_core.sv */
// chained_hash_table_core: key/value hash table with separate chaining
// depends on cht_pkg, cht_if, cht_front, cht_back, cht_ram
//
// channel   dir  payload
// req       in   op, key, data
// rsp       out  hit, result_value, status
// cfg       in   cfg_we, cfg_idx, cfg_data
//
// front: takes a new transaction only when idle, once the bit-serial bucket remainder of the last one is queued
// back: each head and chain entry read passes through a wait state for the registered memory reads
// after reset the head memory is swept before the back takes requests
// a clear that wraps the epoch tag sweeps the head memory again
// a full result register stalls the back, a full queue stalls the front
`default_nettype none
module chained_hash_table_core #(
    parameter int CAPACITY = cht_pkg::CAPACITY_DEF,
    parameter int BUCKETS  = cht_pkg::BUCKETS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    cht_req_if.sink                            req,
    cht_rsp_if.source                          rsp,
    input  wire logic                          cfg_we,
    input  wire logic [cht_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [cht_pkg::CFG_W-1:0]     cfg_data
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    logic [cht_pkg::CFG_W-1:0] bucket_count_reg, entry_limit_reg;
    cht_pkg::req_t in_req, q_req;
    cht_pkg::rsp_t out_rsp;
    logic          q_valid, q_ready;
    logic [BW-1:0] q_bucket;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= cht_pkg::CFG_W'(7);
            entry_limit_reg  <= cht_pkg::CFG_W'(1024);
        end
        else if (cfg_we)
        begin
            if (cfg_idx == cht_pkg::REG_BUCKET_COUNT)
            begin
                bucket_count_reg <= cfg_data;
            end
            else if (cfg_idx == cht_pkg::REG_ENTRY_LIMIT)
            begin
                entry_limit_reg <= cfg_data;
            end
        end
    end

    assign in_req = '{req.op, req.key, req.data};

    cht_front #(.BUCKETS(BUCKETS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready), .in_req(in_req),
        .bucket_count(bucket_count_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req), .q_bucket(q_bucket)
    );

    cht_back #(.CAPACITY(CAPACITY), .BUCKETS(BUCKETS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req), .q_bucket(q_bucket),
        .entry_limit(entry_limit_reg),
        .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(out_rsp)
    );

    assign rsp.hit          = out_rsp.hit;
    assign rsp.result_value = out_rsp.result_value;
    assign rsp.status       = out_rsp.status;
endmodule
`default_nettype wire
